>>> rtl/lde_pkg.sv
// shared widths, types and saturation helpers for the lorenz derivative pipeline
package lde_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int Q_W       = PROD_W - FRAC_BITS;
   localparam int SUM_W     = Q_W + 2;
   localparam int NUM_VEC   = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic signed [DATA_W-1:0] SIGMA_RESET = DATA_W'(655360);
   localparam logic signed [DATA_W-1:0] RHO_RESET   = DATA_W'(1835008);
   localparam logic signed [DATA_W-1:0] BETA_RESET  = DATA_W'(174763);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIGMA   = 2'd0,
      CSR_RHO     = 2'd1,
      CSR_BETA    = 2'd2,
      CSR_TANGENT = 2'd3
   } csr_index_type;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic signed [Q_W-1:0]    qword_type;
   typedef logic signed [SUM_W-1:0]  sword_type;

   typedef struct packed {
      word_type sigma;
      word_type rho;
      word_type beta;
      logic     tangent_en;
   } cfg_type;

   typedef struct packed {
      word_type                  pos_x;
      word_type                  pos_y;
      word_type                  pos_z;
      word_type [NUM_VEC-1:0]    tan_x;
      word_type [NUM_VEC-1:0]    tan_y;
      word_type [NUM_VEC-1:0]    tan_z;
   } in_type;

   typedef struct packed {
      word_type                  x;
      word_type                  y;
      word_type                  z;
      word_type                  dyx;
      word_type                  rmz;
      word_type [NUM_VEC-1:0]    tan_x;
      word_type [NUM_VEC-1:0]    tan_y;
      word_type [NUM_VEC-1:0]    tan_z;
      word_type [NUM_VEC-1:0]    dyx_v;
   } diff_type;

   typedef struct packed {
      qword_type                 q_sdyx;
      qword_type                 q_xrmz;
      qword_type                 q_xy;
      qword_type                 q_bz;
      word_type                  y;
      qword_type [NUM_VEC-1:0]   q_sdv;
      qword_type [NUM_VEC-1:0]   q_rva;
      qword_type [NUM_VEC-1:0]   q_xvc;
      qword_type [NUM_VEC-1:0]   q_yva;
      qword_type [NUM_VEC-1:0]   q_xvb;
      qword_type [NUM_VEC-1:0]   q_bvc;
      word_type  [NUM_VEC-1:0]   tan_y;
   } prod_type;

   typedef struct packed {
      word_type                  rate_x;
      word_type                  rate_y;
      word_type                  rate_z;
      word_type [NUM_VEC-1:0]    trate_x;
      word_type [NUM_VEC-1:0]    trate_y;
      word_type [NUM_VEC-1:0]    trate_z;
   } out_type;

   // a - b, clamped to the signed data range
   function automatic word_type sat_diff(input word_type a, input word_type b);
      logic signed [DATA_W:0] d;
      d = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
      if (d[DATA_W] == d[DATA_W-1]) begin
         return d[DATA_W-1:0];
      end else if (d[DATA_W]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   // clamp a wide sum to the signed data range
   function automatic word_type sat_sum(input sword_type v);
      if (v[SUM_W-1:DATA_W-1] == '0 || v[SUM_W-1:DATA_W-1] == '1) begin
         return v[DATA_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   function automatic sword_type ext_q(input qword_type q);
      return {{(SUM_W-Q_W){q[Q_W-1]}}, q};
   endfunction

   function automatic sword_type ext_w(input word_type w);
      return {{(SUM_W-DATA_W){w[DATA_W-1]}}, w};
   endfunction

endpackage

>>> rtl/lde_if.sv
// request, response and register write channel interfaces
interface lde_req_if import lde_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type pos_x;
   word_type pos_y;
   word_type pos_z;
   word_type tan_x_a;
   word_type tan_x_b;
   word_type tan_x_c;
   word_type tan_y_a;
   word_type tan_y_b;
   word_type tan_y_c;
   word_type tan_z_a;
   word_type tan_z_b;
   word_type tan_z_c;

   modport source (
      output valid, pos_x, pos_y, pos_z, tan_x_a, tan_x_b, tan_x_c,
             tan_y_a, tan_y_b, tan_y_c, tan_z_a, tan_z_b, tan_z_c,
      input  ready
   );
   modport sink (
      input  valid, pos_x, pos_y, pos_z, tan_x_a, tan_x_b, tan_x_c,
             tan_y_a, tan_y_b, tan_y_c, tan_z_a, tan_z_b, tan_z_c,
      output ready
   );
endinterface

interface lde_rsp_if import lde_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type rate_x;
   word_type rate_y;
   word_type rate_z;
   word_type trate_x_a;
   word_type trate_x_b;
   word_type trate_x_c;
   word_type trate_y_a;
   word_type trate_y_b;
   word_type trate_y_c;
   word_type trate_z_a;
   word_type trate_z_b;
   word_type trate_z_c;

   modport source (
      output valid, rate_x, rate_y, rate_z, trate_x_a, trate_x_b, trate_x_c,
             trate_y_a, trate_y_b, trate_y_c, trate_z_a, trate_z_b, trate_z_c,
      input  ready
   );
   modport sink (
      input  valid, rate_x, rate_y, rate_z, trate_x_a, trate_x_b, trate_x_c,
             trate_y_a, trate_y_b, trate_y_c, trate_z_a, trate_z_b, trate_z_c,
      output ready
   );
endinterface

interface lde_csr_if import lde_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lde_csr.sv
// configuration registers for the lorenz coefficients and tangent mode
module lde_csr import lde_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   lde_csr_if.sink csr_chan,
   output cfg_type cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            CSR_SIGMA:   cfg_in.sigma      = $signed(csr_chan.data);
            CSR_RHO:     cfg_in.rho        = $signed(csr_chan.data);
            CSR_BETA:    cfg_in.beta       = $signed(csr_chan.data);
            CSR_TANGENT: cfg_in.tangent_en = csr_chan.data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sigma      <= SIGMA_RESET;
         cfg_ff.rho        <= RHO_RESET;
         cfg_ff.beta       <= BETA_RESET;
         cfg_ff.tangent_en <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/lde_diff_stage.sv
// first stage: saturated differences that feed the multipliers
module lde_diff_stage import lde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  in_type   in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output diff_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   diff_type data_ff;
   diff_type data_in;
   logic     load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.x     = in_data.pos_x;
      data_in.y     = in_data.pos_y;
      data_in.z     = in_data.pos_z;
      data_in.dyx   = sat_diff(in_data.pos_y, in_data.pos_x);
      data_in.rmz   = sat_diff(cfg.rho, in_data.pos_z);
      data_in.tan_x = in_data.tan_x;
      data_in.tan_y = in_data.tan_y;
      data_in.tan_z = in_data.tan_z;
      for (int i = 0; i < NUM_VEC; i++) begin
         data_in.dyx_v[i] = sat_diff(in_data.tan_y[i], in_data.tan_x[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/lde_mul_stage.sv
// second stage: all products, each floored by the fraction width
module lde_mul_stage import lde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  diff_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_data
);

   logic     valid_ff;
   logic     valid_in;
   prod_type data_ff;
   prod_type data_in;
   logic     load;

   // exact product, arithmetic shift gives floor
   function automatic qword_type mulq(input word_type a, input word_type b);
      logic signed [PROD_W-1:0] p;
      p = $signed(a) * $signed(b);
      return p[PROD_W-1:FRAC_BITS];
   endfunction

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.q_sdyx = mulq(cfg.sigma, in_data.dyx);
      data_in.q_xrmz = mulq(in_data.x, in_data.rmz);
      data_in.q_xy   = mulq(in_data.x, in_data.y);
      data_in.q_bz   = mulq(cfg.beta, in_data.z);
      data_in.y      = in_data.y;
      data_in.tan_y  = in_data.tan_y;
      for (int i = 0; i < NUM_VEC; i++) begin
         data_in.q_sdv[i] = mulq(cfg.sigma, in_data.dyx_v[i]);
         data_in.q_rva[i] = mulq(in_data.rmz, in_data.tan_x[i]);
         data_in.q_xvc[i] = mulq(in_data.x, in_data.tan_z[i]);
         data_in.q_yva[i] = mulq(in_data.y, in_data.tan_x[i]);
         data_in.q_xvb[i] = mulq(in_data.x, in_data.tan_y[i]);
         data_in.q_bvc[i] = mulq(cfg.beta, in_data.tan_z[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/lde_sum_stage.sv
// third stage: sums, output saturation and the result register
module lde_sum_stage import lde_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  prod_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output out_type  out_data
);

   logic    valid_ff;
   logic    valid_in;
   out_type data_ff;
   out_type data_in;
   logic    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      data_in.rate_x = sat_sum(ext_q(in_data.q_sdyx));
      data_in.rate_y = sat_sum(ext_q(in_data.q_xrmz) - ext_w(in_data.y));
      data_in.rate_z = sat_sum(ext_q(in_data.q_xy) - ext_q(in_data.q_bz));
      for (int i = 0; i < NUM_VEC; i++) begin
         if (cfg.tangent_en) begin
            data_in.trate_x[i] = sat_sum(ext_q(in_data.q_sdv[i]));
            data_in.trate_y[i] = sat_sum(ext_q(in_data.q_rva[i])
                                         - ext_w(in_data.tan_y[i])
                                         - ext_q(in_data.q_xvc[i]));
            data_in.trate_z[i] = sat_sum(ext_q(in_data.q_yva[i])
                                         + ext_q(in_data.q_xvb[i])
                                         - ext_q(in_data.q_bvc[i]));
         end else begin
            data_in.trate_x[i] = '0;
            data_in.trate_y[i] = '0;
            data_in.trate_z[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/lorenz_derivative_eval.sv
// lorenz right-hand side and variational equations, three-stage pipeline
// structure: three register stages, a request passes the difference, multiply and sum registers in order
// throughput: one request per cycle while rsp_chan.ready holds, set by the difference, multiply and sum stages
// each stage holds its item under back-pressure, so a stall loses nothing
// reset: synchronous, clears all stage valid bits and loads the default coefficients
module lorenz_derivative_eval import lde_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lde_req_if.sink   req_chan,
   lde_rsp_if.source rsp_chan,
   lde_csr_if.sink   csr_chan
);

   cfg_type  cfg;
   in_type   req_data;
   diff_type diff_data;
   prod_type prod_data;
   out_type  rsp_data;
   logic     diff_valid;
   logic     diff_ready;
   logic     prod_valid;
   logic     prod_ready;

   lde_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   always_comb begin
      req_data.pos_x    = req_chan.pos_x;
      req_data.pos_y    = req_chan.pos_y;
      req_data.pos_z    = req_chan.pos_z;
      req_data.tan_x[0] = req_chan.tan_x_a;
      req_data.tan_x[1] = req_chan.tan_x_b;
      req_data.tan_x[2] = req_chan.tan_x_c;
      req_data.tan_y[0] = req_chan.tan_y_a;
      req_data.tan_y[1] = req_chan.tan_y_b;
      req_data.tan_y[2] = req_chan.tan_y_c;
      req_data.tan_z[0] = req_chan.tan_z_a;
      req_data.tan_z[1] = req_chan.tan_z_b;
      req_data.tan_z[2] = req_chan.tan_z_c;
   end

   lde_diff_stage u_diff (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_data  (diff_data)
   );

   lde_mul_stage u_mul (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_data   (diff_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   lde_sum_stage u_sum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.rate_x    = rsp_data.rate_x;
   assign rsp_chan.rate_y    = rsp_data.rate_y;
   assign rsp_chan.rate_z    = rsp_data.rate_z;
   assign rsp_chan.trate_x_a = rsp_data.trate_x[0];
   assign rsp_chan.trate_x_b = rsp_data.trate_x[1];
   assign rsp_chan.trate_x_c = rsp_data.trate_x[2];
   assign rsp_chan.trate_y_a = rsp_data.trate_y[0];
   assign rsp_chan.trate_y_b = rsp_data.trate_y[1];
   assign rsp_chan.trate_y_c = rsp_data.trate_y[2];
   assign rsp_chan.trate_z_a = rsp_data.trate_z[0];
   assign rsp_chan.trate_z_b = rsp_data.trate_z[1];
   assign rsp_chan.trate_z_c = rsp_data.trate_z[2];

endmodule

>>> bench/tb_lorenz_derivative_eval.sv
// self-checking bench for the lorenz derivative pipeline with tangent vectors
module tb_lorenz_derivative_eval import lde_pkg::*; ();

   localparam word_type TOP_WORD    = 32'sh7FFF_FFFF;
   localparam word_type BOTTOM_WORD = 32'sh8000_0000;
   localparam word_type UNIT_WORD   = 32'sh0001_0000;
   localparam int       PHASES      = 7;
   localparam int       PHASE_ITEMS = 198;
   localparam int       LONG_HOLD   = 200;
   localparam int       CYCLE_LIMIT = 500000;

   class rate_ledger;
      cfg_type coeffs;
      out_type awaited[$];
      int      noted;
      int      compared;
      int      failures;

      function new();
         coeffs.sigma      = SIGMA_RESET;
         coeffs.rho        = RHO_RESET;
         coeffs.beta       = BETA_RESET;
         coeffs.tangent_en = 1'b1;
         noted             = 0;
         compared          = 0;
         failures          = 0;
      endfunction

      function void apply_write(csr_index_type idx, logic [DATA_W-1:0] value);
         case (idx)
            CSR_SIGMA:   coeffs.sigma      = value;
            CSR_RHO:     coeffs.rho        = value;
            CSR_BETA:    coeffs.beta       = value;
            CSR_TANGENT: coeffs.tangent_en = value[0];
            default: ;
         endcase
      endfunction

      function longint fix_mul(longint a, longint b);
         // arithmetic shift of the exact product rounds toward minus infinity
         return (a * b) >>> FRAC_BITS;
      endfunction

      function word_type clamp(longint v);
         if (v > 64'sd2147483647) return TOP_WORD;
         if (v < -64'sd2147483648) return BOTTOM_WORD;
         return word_type'(v);
      endfunction

      function out_type derive(in_type pt);
         out_type r;
         longint  x, y, z, sg, rg, bg, rmz, va, vb, vc;
         x   = pt.pos_x;
         y   = pt.pos_y;
         z   = pt.pos_z;
         sg  = coeffs.sigma;
         rg  = coeffs.rho;
         bg  = coeffs.beta;
         rmz = clamp(rg - z);
         r.rate_x = clamp(fix_mul(sg, clamp(y - x)));
         r.rate_y = clamp(fix_mul(x, rmz) - y);
         r.rate_z = clamp(fix_mul(x, y) - fix_mul(bg, z));
         for (int i = 0; i < NUM_VEC; i++) begin
            va = $signed(pt.tan_x[i]);
            vb = $signed(pt.tan_y[i]);
            vc = $signed(pt.tan_z[i]);
            if (coeffs.tangent_en) begin
               r.trate_x[i] = clamp(fix_mul(sg, clamp(vb - va)));
               r.trate_y[i] = clamp(fix_mul(rmz, va) - vb - fix_mul(x, vc));
               r.trate_z[i] = clamp(fix_mul(y, va) + fix_mul(x, vb) - fix_mul(bg, vc));
            end else begin
               r.trate_x[i] = '0;
               r.trate_y[i] = '0;
               r.trate_z[i] = '0;
            end
         end
         return r;
      endfunction

      function void note_request(in_type pt);
         awaited.push_back(derive(pt));
         noted++;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      task report(string what);
         failures++;
         $display("MISMATCH: %s", what);
      endtask

      task compare_field(string name, word_type got, word_type want);
         if (got !== want)
            report($sformatf("result %0d %s got %h expected %h", compared, name, got, want));
      endtask

      task check_response(out_type got);
         out_type want;
         if (awaited.size() == 0) begin
            report("result transfer with nothing outstanding");
            return;
         end
         want = awaited.pop_front();
         compare_field("rate_x", got.rate_x, want.rate_x);
         compare_field("rate_y", got.rate_y, want.rate_y);
         compare_field("rate_z", got.rate_z, want.rate_z);
         for (int i = 0; i < NUM_VEC; i++) begin
            compare_field($sformatf("trate_x[%0d]", i), got.trate_x[i], want.trate_x[i]);
            compare_field($sformatf("trate_y[%0d]", i), got.trate_y[i], want.trate_y[i]);
            compare_field($sformatf("trate_z[%0d]", i), got.trate_z[i], want.trate_z[i]);
         end
         compared++;
      endtask
   endclass

   logic clock;
   logic reset;

   lde_req_if req_bus ();
   lde_rsp_if rsp_bus ();
   lde_csr_if csr_bus ();

   lorenz_derivative_eval u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   rate_ledger ledger = new();

   int      cycle_count = 0;
   int      csr_writes  = 0;
   int      holds_asked = 0;
   int      holds_taken = 0;
   int      hold_left   = 0;
   int      stall_left  = 0;
   int      flow_left   = 0;
   logic    rsp_idle_on = 1'b1;
   logic    send_idle_on;
   out_type seen;

   initial begin : clock_gen
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lorenz_derivative_eval verification failed");
      $finish;
   end

   // result side: check each transfer, then pick ready for the next edge
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
         seen.rate_x     = rsp_bus.rate_x;
         seen.rate_y     = rsp_bus.rate_y;
         seen.rate_z     = rsp_bus.rate_z;
         seen.trate_x[0] = rsp_bus.trate_x_a;
         seen.trate_x[1] = rsp_bus.trate_x_b;
         seen.trate_x[2] = rsp_bus.trate_x_c;
         seen.trate_y[0] = rsp_bus.trate_y_a;
         seen.trate_y[1] = rsp_bus.trate_y_b;
         seen.trate_y[2] = rsp_bus.trate_y_c;
         seen.trate_z[0] = rsp_bus.trate_z_a;
         seen.trate_z[1] = rsp_bus.trate_z_b;
         seen.trate_z[2] = rsp_bus.trate_z_c;
         ledger.check_response(seen);
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else if (holds_taken != holds_asked) begin
         holds_taken++;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!rsp_idle_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (flow_left > 0) begin
         rsp_bus.ready <= 1'b1;
         flow_left--;
      end else if ($urandom_range(0, 2) == 0) begin
         stall_left = $urandom_range(1, 10) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         flow_left = $urandom_range(1, 24) - 1;
         rsp_bus.ready <= 1'b1;
      end
   end

   function automatic word_type pick_word();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return $signed($urandom_range(0, 32'h0078_0000)) - 32'sh003C_0000;
         5, 6:          return $urandom;
         7, 8: begin
            case ($urandom_range(0, 6))
               0:       return TOP_WORD;
               1:       return BOTTOM_WORD;
               2:       return '0;
               3:       return -32'sd1;
               4:       return 32'sd1;
               5:       return UNIT_WORD;
               default: return -UNIT_WORD;
            endcase
         end
         default:       return $signed($urandom_range(0, 16)) - 32'sd8;
      endcase
   endfunction

   function automatic in_type random_point();
      in_type pt;
      pt.pos_x = pick_word();
      pt.pos_y = pick_word();
      pt.pos_z = pick_word();
      for (int i = 0; i < NUM_VEC; i++) begin
         pt.tan_x[i] = pick_word();
         pt.tan_y[i] = pick_word();
         pt.tan_z[i] = pick_word();
      end
      return pt;
   endfunction

   function automatic void fill_tangents(inout in_type pt, input word_type a,
                                         input word_type b, input word_type c);
      for (int i = 0; i < NUM_VEC; i++) begin
         pt.tan_x[i] = a;
         pt.tan_y[i] = b;
         pt.tan_z[i] = c;
      end
   endfunction

   function automatic int idle_gap();
      if (send_idle_on && $urandom_range(0, 3) == 0) return $urandom_range(1, 10);
      return 0;
   endfunction

   task automatic drive_point(input in_type pt);
      req_bus.pos_x   <= pt.pos_x;
      req_bus.pos_y   <= pt.pos_y;
      req_bus.pos_z   <= pt.pos_z;
      req_bus.tan_x_a <= pt.tan_x[0];
      req_bus.tan_x_b <= pt.tan_x[1];
      req_bus.tan_x_c <= pt.tan_x[2];
      req_bus.tan_y_a <= pt.tan_y[0];
      req_bus.tan_y_b <= pt.tan_y[1];
      req_bus.tan_y_c <= pt.tan_y[2];
      req_bus.tan_z_a <= pt.tan_z[0];
      req_bus.tan_z_b <= pt.tan_z[1];
      req_bus.tan_z_c <= pt.tan_z[2];
   endtask

   // valid stays high into the next point unless a gap follows
   task automatic offer_point(input in_type pt, input int gap);
      req_bus.valid <= 1'b1;
      drive_point(pt);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ledger.note_request(pt);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      ledger.apply_write(idx, value);
      csr_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      in_type            pt;
      logic [DATA_W-1:0] gains [3];
      logic [DATA_W-1:0] tangent_word;

      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      drive_point('0);
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_SIGMA;
      csr_bus.data  <= '0;
      send_idle_on  = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corners under the reset coefficients
      for (int k = 0; k < 12; k++) begin
         pt = '0;
         case (k)
            0: ;
            1: begin
               pt.pos_x = TOP_WORD; pt.pos_y = TOP_WORD; pt.pos_z = TOP_WORD;
               fill_tangents(pt, TOP_WORD, TOP_WORD, TOP_WORD);
            end
            2: begin
               pt.pos_x = BOTTOM_WORD; pt.pos_y = BOTTOM_WORD; pt.pos_z = BOTTOM_WORD;
               fill_tangents(pt, BOTTOM_WORD, BOTTOM_WORD, BOTTOM_WORD);
            end
            3: begin
               // differences clamp high
               pt.pos_x = BOTTOM_WORD; pt.pos_y = TOP_WORD; pt.pos_z = TOP_WORD;
               fill_tangents(pt, BOTTOM_WORD, TOP_WORD, TOP_WORD);
            end
            4: begin
               // differences clamp low, rho minus z clamps high
               pt.pos_x = TOP_WORD; pt.pos_y = BOTTOM_WORD; pt.pos_z = BOTTOM_WORD;
               fill_tangents(pt, TOP_WORD, BOTTOM_WORD, BOTTOM_WORD);
            end
            5: begin
               pt.pos_x = UNIT_WORD; pt.pos_y = UNIT_WORD; pt.pos_z = UNIT_WORD;
               pt.tan_x[0] = UNIT_WORD; pt.tan_y[1] = UNIT_WORD; pt.tan_z[2] = UNIT_WORD;
            end
            6: begin
               // tiny negative products floor to minus one lsb
               pt.pos_x = -32'sd1; pt.pos_y = 32'sd1; pt.pos_z = -32'sd1;
               fill_tangents(pt, -32'sd1, 32'sd1, -32'sd1);
            end
            7: begin
               pt.pos_x = TOP_WORD; pt.pos_y = TOP_WORD;
               fill_tangents(pt, TOP_WORD, '0, BOTTOM_WORD);
            end
            8: begin
               pt = random_point();
               pt.pos_x = 32'shFFF7_8000; pt.pos_y = 32'sh0007_3333; pt.pos_z = 32'sh001B_0000;
            end
            9: begin
               pt.pos_x = 32'shAAAA_AAAA; pt.pos_y = 32'sh5555_5555; pt.pos_z = 32'shAAAA_AAAA;
               fill_tangents(pt, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555);
            end
            10: begin
               pt.pos_x = BOTTOM_WORD; pt.pos_y = BOTTOM_WORD; pt.pos_z = TOP_WORD;
               fill_tangents(pt, BOTTOM_WORD, BOTTOM_WORD, TOP_WORD);
            end
            default: begin
               pt.pos_x = -32'sd3; pt.pos_y = 32'sd5; pt.pos_z = -32'sd7;
               fill_tangents(pt, 32'sd7, -32'sd3, -32'sd5);
            end
         endcase
         offer_point(pt, idle_gap());
      end

      for (int phase = 1; phase <= PHASES; phase++) begin
         req_bus.valid <= 1'b0;
         wait_drained();
         case (phase)
            1: begin
               gains = '{TOP_WORD, BOTTOM_WORD, TOP_WORD};
               tangent_word = 32'hFFFF_FFFE;
            end
            2: begin
               gains = '{BOTTOM_WORD, TOP_WORD, BOTTOM_WORD};
               tangent_word = 32'h8000_0001;
            end
            3: begin
               gains = '{32'h0, 32'h0, 32'h0};
               tangent_word = 32'h7FFF_FFFF;
            end
            4: begin
               gains = '{SIGMA_RESET, RHO_RESET, BETA_RESET};
               tangent_word = 32'h0;
            end
            5, 7: begin
               gains = '{$urandom_range(0, 32'h0014_0000), $urandom_range(0, 32'h0040_0000),
                         $urandom_range(0, 32'h0008_0000)};
               tangent_word = $urandom | 32'h1;
            end
            default: begin
               gains = '{pick_word(), pick_word(), pick_word()};
               tangent_word = $urandom;
            end
         endcase
         write_reg(CSR_SIGMA, gains[0]);
         write_reg(CSR_RHO, gains[1]);
         write_reg(CSR_BETA, gains[2]);
         write_reg(CSR_TANGENT, tangent_word);

         // phase two: sender streams flat out into a long receiver hold-off
         send_idle_on = (phase != 2 && phase != PHASES);
         if (phase == 2) holds_asked <= holds_asked + 1;
         if (phase == PHASES) rsp_idle_on <= 1'b0;
         for (int n = 0; n < PHASE_ITEMS; n++) offer_point(random_point(), idle_gap());
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (ledger.pending() != 0)
         ledger.report($sformatf("%0d results never arrived", ledger.pending()));
      $display("run covered %0d state points over %0d coefficient settings (%0d register writes)",
               ledger.noted, PHASES + 1, csr_writes);
      $display("%0d result transfers compared field by field, %0d mismatches",
               ledger.compared, ledger.failures);
      if (ledger.failures == 0) begin
         $display("lorenz_derivative_eval verification clean");
      end else begin
         $display("lorenz_derivative_eval verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/lde_pkg.sv
rtl/lde_if.sv
rtl/lde_csr.sv
rtl/lde_diff_stage.sv
rtl/lde_mul_stage.sv
rtl/lde_sum_stage.sv
rtl/lorenz_derivative_eval.sv
bench/tb_lorenz_derivative_eval.sv
